@@ rtl/tsq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_pkg
// shared constants, codes and types of the two-stack queue
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 11;
  localparam int CFG_INDEX_W = 1;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] STAT_ENQ   = 2'd0;
  localparam logic [1:0] STAT_DEQ   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CAP  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_CAP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DRAIN,
    ST_FINISH,
    ST_POP
  } state_t;

  // effective stack capacities
  typedef struct packed {
    logic [COUNT_W-1:0] in_cap;
    logic [COUNT_W-1:0] out_cap;
  } caps_t;

  // one ram access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage : tsq_pkg
`default_nettype wire

@@ rtl/two_stack_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_stack_queue
// first-in first-out queue of 32-bit words built from two ram-based stacks
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each item gives exactly
// one result word, shown on status and result_value for one cycle while done
// is high. The receiver cannot stall, so the result must be captured in that
// cycle. A new word can be taken once busy falls again; apart from a move, an
// enqueue passes through the finish state, a dequeue that returns a word
// through the finish and pop states and a dequeue that finds both stacks
// empty through the finish state alone; busy is high in between, and the
// result word is shown in the cycle in which busy falls. When the output
// stack is empty and must be refilled, the whole input stack is moved first,
// in the move and drain states, at one word per cycle through the input
// ram read port. Each word moves once. The input stack holds the smaller of
// the two configured capacities, the output stack the larger; a capacity of
// zero acts as one and one above 1024 acts as 1024. Capacity writes go
// through the cfg channel, which is always ready, and are to be made only
// while idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module two_stack_queue
  import tsq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command side
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic                   operation,
  input  wire logic signed [DATA_W-1:0] entry_value,
  // result side
  output      logic                   done,
  output      logic [1:0]             status,
  output      logic signed [DATA_W-1:0] result_value,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]       cfg_data
);

  // capacity registers, reset to full depth
  logic [CAP_W-1:0]   first_capacity;
  logic [CAP_W-1:0]   second_capacity;
  logic [COUNT_W-1:0] first_eff;
  logic [COUNT_W-1:0] second_eff;
  caps_t              caps;

  ram_req_t           in_req;
  ram_req_t           out_req;
  logic [DATA_W-1:0]  in_rdata;
  logic [DATA_W-1:0]  out_rdata;
  logic [DATA_W-1:0]  result_raw;

  // writes are to be made only while idle; the block does not enforce it, and the channel never pushes back
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_capacity  <= CAP_W'(STACK_DEPTH);
      second_capacity <= CAP_W'(STACK_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_CAP:  first_capacity  <= cfg_data;
        REG_SECOND_CAP: second_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp each capacity into 1..depth, then the smaller sizes the input stack
  always_comb begin
    if (first_capacity == '0) begin
      first_eff = COUNT_W'(1);
    end else if (first_capacity > CAP_W'(STACK_DEPTH)) begin
      first_eff = COUNT_W'(STACK_DEPTH);
    end else begin
      first_eff = COUNT_W'(first_capacity);
    end

    if (second_capacity == '0) begin
      second_eff = COUNT_W'(1);
    end else if (second_capacity > CAP_W'(STACK_DEPTH)) begin
      second_eff = COUNT_W'(STACK_DEPTH);
    end else begin
      second_eff = COUNT_W'(second_capacity);
    end

    if (first_eff < second_eff) begin
      caps.in_cap  = first_eff;
      caps.out_cap = second_eff;
    end else begin
      caps.in_cap  = second_eff;
      caps.out_cap = first_eff;
    end
  end

  tsq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .entry_value  (entry_value),
    .caps         (caps),
    .in_rdata     (in_rdata),
    .out_rdata    (out_rdata),
    .in_req       (in_req),
    .out_req      (out_req),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_value (result_raw)
  );

  assign result_value = result_raw;

  // input stack: pushed by enqueue, popped by the move
  tsq_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_req.we),
    .waddr (in_req.waddr),
    .wdata (in_req.wdata),
    .re    (in_req.re),
    .raddr (in_req.raddr),
    .rdata (in_rdata)
  );

  // output stack: filled by the move, popped by dequeue
  tsq_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_req.we),
    .waddr (out_req.waddr),
    .wdata (out_req.wdata),
    .re    (out_req.re),
    .raddr (out_req.raddr),
    .rdata (out_rdata)
  );

endmodule : two_stack_queue
`default_nettype wire

@@ rtl/tsq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tsq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tsq_ram
`default_nettype wire

@@ rtl/tsq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_ctrl
// sequencer: stack counts, input-to-output move and result register
// ----------------------------------------------------------------------------
module tsq_ctrl
  import tsq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              operation,
  input  wire logic [DATA_W-1:0] entry_value,
  input  wire caps_t             caps,
  input  wire logic [DATA_W-1:0] in_rdata,
  input  wire logic [DATA_W-1:0] out_rdata,
  output      ram_req_t          in_req,
  output      ram_req_t          out_req,
  output      logic              busy,
  output      logic              done,
  output      logic [1:0]        status,
  output      logic [DATA_W-1:0] result_value
);

  state_t             state, state_next;
  logic [COUNT_W-1:0] in_cnt, in_cnt_next;
  logic [COUNT_W-1:0] out_cnt, out_cnt_next;
  logic               mv_pend, mv_pend_next;
  logic               op, op_next;
  logic [DATA_W-1:0]  value, value_next;
  logic               done_next;
  logic [1:0]         status_next;
  logic [DATA_W-1:0]  result_value_next;
  logic               need_move;
  logic [COUNT_W-1:0] in_top;
  logic [COUNT_W-1:0] out_top;

  assign in_top  = in_cnt - COUNT_W'(1);
  assign out_top = out_cnt - COUNT_W'(1);
  assign busy    = (state != ST_IDLE);

  // move when output stack empty and input has data (enqueue: input also full)
  always_comb begin
    if (operation == OP_ENQ) begin
      need_move = (in_cnt >= caps.in_cap) && (out_cnt == '0) && (in_cnt != '0);
    end else begin
      need_move = (out_cnt == '0) && (in_cnt != '0);
    end
  end

  always_comb begin
    state_next        = state;
    in_cnt_next       = in_cnt;
    out_cnt_next      = out_cnt;
    mv_pend_next      = 1'b0;
    op_next           = op;
    value_next        = value;
    done_next         = 1'b0;
    status_next       = status;
    result_value_next = result_value;
    in_req            = '0;
    out_req           = '0;

    // write side of the move: data read in the previous cycle
    if (mv_pend) begin
      if (out_cnt < caps.out_cap) begin
        out_req.we    = 1'b1;
        out_req.waddr = out_cnt[ADDR_W-1:0];
        out_req.wdata = in_rdata;
        out_cnt_next  = out_cnt + COUNT_W'(1);
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = operation;
          value_next = entry_value;
          state_next = need_move ? ST_MOVE : ST_FINISH;
        end
      end
      ST_MOVE: begin
        in_req.re    = 1'b1;
        in_req.raddr = in_top[ADDR_W-1:0];
        in_cnt_next  = in_top;
        mv_pend_next = 1'b1;
        if (in_cnt == COUNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        result_value_next = '0;
        if (op == OP_ENQ) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (in_cnt < caps.in_cap) begin
            in_req.we    = 1'b1;
            in_req.waddr = in_cnt[ADDR_W-1:0];
            in_req.wdata = value;
            in_cnt_next  = in_cnt + COUNT_W'(1);
            status_next  = STAT_ENQ;
          end else begin
            status_next = STAT_FULL;
          end
        end else if (out_cnt != '0) begin
          out_req.re    = 1'b1;
          out_req.raddr = out_top[ADDR_W-1:0];
          out_cnt_next  = out_top;
          state_next    = ST_POP;
        end else begin
          done_next   = 1'b1;
          status_next = STAT_EMPTY;
          state_next  = ST_IDLE;
        end
      end
      ST_POP: begin
        done_next         = 1'b1;
        status_next       = STAT_DEQ;
        result_value_next = out_rdata;
        state_next        = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_cnt  <= '0;
      out_cnt <= '0;
      mv_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      in_cnt  <= in_cnt_next;
      out_cnt <= out_cnt_next;
      mv_pend <= mv_pend_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    value        <= value_next;
    status       <= status_next;
    result_value <= result_value_next;
  end

endmodule : tsq_ctrl
`default_nettype wire
